// ===== rtl/handle_table_packed_vec4_store_defines.svh =====
// ---------------------------------------------------------------------------
// handle_table_packed_vec4_store_defines
// Assertion macros for the handle table block.
// ---------------------------------------------------------------------------
`ifndef HANDLE_TABLE_PACKED_VEC4_STORE_DEFINES_SVH
`define HANDLE_TABLE_PACKED_VEC4_STORE_DEFINES_SVH

// check that cond implies prop in the same cycle
`define HTPS_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// check that cond implies prop in the next cycle
`define HTPS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/htps_pkg.sv =====
// ---------------------------------------------------------------------------
// htps_pkg
// Types and constants shared by the handle table controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package htps_pkg;

	localparam int HANDLE_W = 8;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int CHAN_W   = 2;
	localparam int CFG_W    = 3;
	localparam int WORD_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int REC_AW   = SLOT_W + CHAN_W;

	localparam logic [CFG_W-1:0] MAX_CHANNELS = 3'd4;

	localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_SET      = 3'd2;
	localparam logic [OP_W-1:0] OP_GET      = 3'd3;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CHANNEL = 2'd3;

	typedef struct packed {
		logic              take;
		logic              look;
		logic              decide;
		logic              zero_wr;
		logic              copy_rd;
		logic              copy_wr;
		logic              remap;
		logic              get_cap;
		logic              load_out;
		logic [CHAN_W-1:0] rec_k;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            live;
		logic            chan_ok;
		logic            out_busy;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/handle_table_packed_vec4_store.sv =====
// ---------------------------------------------------------------------------
// handle_table_packed_vec4_store
// Handle table over a densely packed store of four-word channel records.
// ---------------------------------------------------------------------------
// One request at a time. After the accepting edge come the lookup and the
// decision; an add that succeeds then makes four record zeroing writes, a
// remove that succeeds makes four record moves (each a read and a write on the
// single-port record memory) and then the map update, and a get that hits reads
// the record; set, contains, unused opcodes and every error go straight on to
// the result load. in_ready rises in the cycle after the result is loaded into
// the output register, even while that result waits for out_ready; a result
// still waiting when the next one is ready holds the next one, and so the next
// request, back.
`default_nettype none
`include "handle_table_packed_vec4_store_defines.svh"

module handle_table_packed_vec4_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [htps_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [htps_pkg::OP_W-1:0]     opcode,
	input  wire logic [htps_pkg::HANDLE_W-1:0] handle,
	input  wire logic [htps_pkg::CHAN_W-1:0]   channel,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_x,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_y,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_z,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_w,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [htps_pkg::STATUS_W-1:0]      status,
	output logic [htps_pkg::HANDLE_W-1:0]      new_handle,
	output logic                               present,
	output logic [htps_pkg::WORD_W-1:0]        read_x,
	output logic [htps_pkg::WORD_W-1:0]        read_y,
	output logic [htps_pkg::WORD_W-1:0]        read_z,
	output logic [htps_pkg::WORD_W-1:0]        read_w
);

	htps_pkg::cmd_t  cmd;
	htps_pkg::stat_t stat;
	logic [8:0]      cmd_bits;

	assign cmd_bits = {cmd.take, cmd.look, cmd.decide, cmd.zero_wr, cmd.copy_rd,
		cmd.copy_wr, cmd.remap, cmd.get_cap, cmd.load_out};

	htps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	htps_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.opcode     (opcode),
		.handle     (handle),
		.channel    (channel),
		.word_x     (word_x),
		.word_y     (word_y),
		.word_z     (word_z),
		.word_w     (word_w),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.new_handle (new_handle),
		.present    (present),
		.read_x     (read_x),
		.read_y     (read_y),
		.read_z     (read_z),
		.read_w     (read_w)
	);

	`HTPS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "request taken while busy")
	`HTPS_ASSERT_NOW(a_load_slot_free, cmd.load_out, !out_valid || out_ready, "result overwritten")
	`HTPS_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd_bits), "command overlap")

endmodule

`default_nettype wire

// ===== rtl/htps_datapath.sv =====
// ---------------------------------------------------------------------------
// htps_datapath
// Handle maps, free handle queue, record store and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module htps_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire htps_pkg::cmd_t                cmd,
	output htps_pkg::stat_t                    stat,
	input  wire logic                          cfg_we,
	input  wire logic [htps_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic [htps_pkg::OP_W-1:0]     opcode,
	input  wire logic [htps_pkg::HANDLE_W-1:0] handle,
	input  wire logic [htps_pkg::CHAN_W-1:0]   channel,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_x,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_y,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_z,
	input  wire logic [htps_pkg::WORD_W-1:0]   word_w,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [htps_pkg::STATUS_W-1:0]      status,
	output logic [htps_pkg::HANDLE_W-1:0]      new_handle,
	output logic                               present,
	output logic [htps_pkg::WORD_W-1:0]        read_x,
	output logic [htps_pkg::WORD_W-1:0]        read_y,
	output logic [htps_pkg::WORD_W-1:0]        read_z,
	output logic [htps_pkg::WORD_W-1:0]        read_w
);

	localparam int NSLOT = 2 ** htps_pkg::SLOT_W;
	localparam int NREC  = 2 ** htps_pkg::REC_AW;
	localparam int REC_W = 4 * htps_pkg::WORD_W;

	logic [htps_pkg::CFG_W-1:0]    cfg_q;
	logic [htps_pkg::OP_W-1:0]     op_q;
	logic [htps_pkg::HANDLE_W-1:0] hdl_q;
	logic [htps_pkg::CHAN_W-1:0]   ch_q;
	logic [REC_W-1:0]              words_q;
	logic [htps_pkg::SLOT_W-1:0]   slot_q;
	logic [htps_pkg::HANDLE_W-1:0] lh_q;
	logic [NSLOT-1:0]              live_q;
	logic [NSLOT-1:0]              fqv_q;
	logic                          fqv_rd_q;
	logic [htps_pkg::HANDLE_W-1:0] head_q;
	logic [htps_pkg::HANDLE_W-1:0] tail_q;
	logic [htps_pkg::COUNT_W-1:0]  lc_q;
	logic                          out_valid_q;

	logic [htps_pkg::STATUS_W-1:0] res_status_q;
	logic [htps_pkg::HANDLE_W-1:0] res_nh_q;
	logic                          res_pres_q;
	logic [REC_W-1:0]              res_rd_q;
	logic [htps_pkg::STATUS_W-1:0] status_q;
	logic [htps_pkg::HANDLE_W-1:0] nh_q;
	logic                          pres_q;
	logic [REC_W-1:0]              rd_q;

	logic [htps_pkg::SLOT_W-1:0]   h2s_mem [NSLOT];
	logic [htps_pkg::HANDLE_W-1:0] s2h_mem [NSLOT];
	logic [htps_pkg::HANDLE_W-1:0] fq_mem  [NSLOT];
	logic [REC_W-1:0]              rec_mem [NREC];
	logic [htps_pkg::SLOT_W-1:0]   h2s_rd;
	logic [htps_pkg::HANDLE_W-1:0] s2h_rd;
	logic [htps_pkg::HANDLE_W-1:0] fq_rd;
	logic [REC_W-1:0]              rec_rd;

	logic                          h2s_we, s2h_we, fq_we, rec_we;
	logic [htps_pkg::SLOT_W-1:0]   h2s_addr, h2s_wd;
	logic [htps_pkg::SLOT_W-1:0]   s2h_addr;
	logic [htps_pkg::HANDLE_W-1:0] s2h_wd;
	logic [htps_pkg::HANDLE_W-1:0] fq_addr;
	logic [htps_pkg::REC_AW-1:0]   rec_addr;
	logic [REC_W-1:0]              rec_wd;

	logic [htps_pkg::SLOT_W-1:0]   last_slot;
	logic [htps_pkg::HANDLE_W-1:0] fh;
	logic                          hdl_live;
	logic [htps_pkg::CFG_W-1:0]    eff_ch;
	logic                          chan_ok;
	logic                          full;
	logic                          add_ok;
	logic [htps_pkg::STATUS_W-1:0] dec_status;

	always_comb begin
		last_slot = lc_q[htps_pkg::SLOT_W-1:0] - 1'b1;
		fh        = fqv_rd_q ? fq_rd : head_q;
		hdl_live  = live_q[hdl_q];
		eff_ch    = (cfg_q > htps_pkg::MAX_CHANNELS) ? htps_pkg::MAX_CHANNELS : cfg_q;
		chan_ok   = {1'b0, ch_q} < eff_ch;
		full      = lc_q[htps_pkg::COUNT_W-1];
		add_ok    = cmd.decide && (op_q == htps_pkg::OP_ADD) && !full;
	end

	always_comb begin
		case (op_q)
			htps_pkg::OP_ADD:    dec_status = full ? htps_pkg::ST_FULL : htps_pkg::ST_OK;
			htps_pkg::OP_REMOVE: dec_status = hdl_live ? htps_pkg::ST_OK : htps_pkg::ST_ABSENT;
			htps_pkg::OP_SET,
			htps_pkg::OP_GET: begin
				if (!hdl_live)
					dec_status = htps_pkg::ST_ABSENT;
				else if (!chan_ok)
					dec_status = htps_pkg::ST_CHANNEL;
				else
					dec_status = htps_pkg::ST_OK;
			end
			default:             dec_status = htps_pkg::ST_OK;
		endcase
	end

	always_comb begin
		h2s_we   = add_ok || cmd.remap;
		h2s_addr = cmd.remap ? lh_q : (cmd.decide ? fh : hdl_q);
		h2s_wd   = cmd.remap ? slot_q : lc_q[htps_pkg::SLOT_W-1:0];
		s2h_we   = add_ok || cmd.remap;
		s2h_addr = cmd.remap ? slot_q :
			(cmd.decide ? lc_q[htps_pkg::SLOT_W-1:0] : last_slot);
		s2h_wd   = cmd.remap ? lh_q : fh;
		fq_we    = cmd.remap;
		fq_addr  = cmd.remap ? tail_q : head_q;
	end

	always_comb begin
		rec_we   = 1'b0;
		rec_addr = {last_slot, cmd.rec_k};
		rec_wd   = '0;
		if (cmd.zero_wr) begin
			rec_we   = 1'b1;
			rec_addr = {lc_q[htps_pkg::SLOT_W-1:0], cmd.rec_k};
		end else if (cmd.copy_rd) begin
			rec_addr = {last_slot, cmd.rec_k};
		end else if (cmd.copy_wr) begin
			rec_we   = 1'b1;
			rec_addr = {slot_q, cmd.rec_k};
			rec_wd   = rec_rd;
		end else if (cmd.decide) begin
			rec_we   = (op_q == htps_pkg::OP_SET) && hdl_live && chan_ok;
			rec_addr = {h2s_rd, ch_q};
			rec_wd   = words_q;
		end
	end

	always_ff @(posedge clk) begin
		if (h2s_we)
			h2s_mem[h2s_addr] <= h2s_wd;
		h2s_rd <= h2s_mem[h2s_addr];
	end

	always_ff @(posedge clk) begin
		if (s2h_we)
			s2h_mem[s2h_addr] <= s2h_wd;
		s2h_rd <= s2h_mem[s2h_addr];
	end

	always_ff @(posedge clk) begin
		if (fq_we)
			fq_mem[fq_addr] <= hdl_q;
		fq_rd <= fq_mem[fq_addr];
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[rec_addr] <= rec_wd;
		rec_rd <= rec_mem[rec_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= htps_pkg::MAX_CHANNELS;
			live_q      <= '0;
			fqv_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			lc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (add_ok) begin
				live_q[fh] <= 1'b1;
				head_q     <= head_q + 1'b1;
			end
			if (cmd.zero_wr && (cmd.rec_k == '1))
				lc_q <= lc_q + 1'b1;
			if (cmd.remap) begin
				live_q[hdl_q] <= 1'b0;
				fqv_q[tail_q] <= 1'b1;
				tail_q        <= tail_q + 1'b1;
				lc_q          <= lc_q - 1'b1;
			end
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= opcode;
			hdl_q   <= handle;
			ch_q    <= channel;
			words_q <= {word_w, word_z, word_y, word_x};
		end
		if (cmd.look)
			fqv_rd_q <= fqv_q[head_q];
		if (cmd.decide) begin
			slot_q       <= h2s_rd;
			lh_q         <= s2h_rd;
			res_status_q <= dec_status;
			res_nh_q     <= add_ok ? fh : '0;
			res_pres_q   <= (op_q == htps_pkg::OP_CONTAINS) && hdl_live;
			res_rd_q     <= '0;
		end
		if (cmd.get_cap)
			res_rd_q <= rec_rd;
		if (cmd.load_out) begin
			status_q <= res_status_q;
			nh_q     <= res_nh_q;
			pres_q   <= res_pres_q;
			rd_q     <= res_rd_q;
		end
	end

	always_comb begin
		stat.op       = op_q;
		stat.full     = full;
		stat.live     = hdl_live;
		stat.chan_ok  = chan_ok;
		stat.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign new_handle = nh_q;
	assign present    = pres_q;
	assign read_x     = rd_q[htps_pkg::WORD_W-1:0];
	assign read_y     = rd_q[2*htps_pkg::WORD_W-1:htps_pkg::WORD_W];
	assign read_z     = rd_q[3*htps_pkg::WORD_W-1:2*htps_pkg::WORD_W];
	assign read_w     = rd_q[4*htps_pkg::WORD_W-1:3*htps_pkg::WORD_W];

endmodule

`default_nettype wire

// ===== rtl/htps_ctrl.sv =====
// ---------------------------------------------------------------------------
// htps_ctrl
// Sequencer for the handle table: lookup, decision, record loops, result.
// ---------------------------------------------------------------------------
`default_nettype none

module htps_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire htps_pkg::stat_t stat,
	output htps_pkg::cmd_t       cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LOOK    = 4'd1;
	localparam logic [3:0] S_DEC     = 4'd2;
	localparam logic [3:0] S_ZERO    = 4'd3;
	localparam logic [3:0] S_COPY_RD = 4'd4;
	localparam logic [3:0] S_COPY_WR = 4'd5;
	localparam logic [3:0] S_REMAP   = 4'd6;
	localparam logic [3:0] S_GET     = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]                  state_q, state_d;
	logic [htps_pkg::CHAN_W-1:0] k_q, k_d;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cmd      = '0;
		cmd.rec_k = k_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				k_d        = '0;
				state_d    = S_DONE;
				if (stat.op == htps_pkg::OP_ADD && !stat.full)
					state_d = S_ZERO;
				else if (stat.op == htps_pkg::OP_REMOVE && stat.live)
					state_d = S_COPY_RD;
				else if (stat.op == htps_pkg::OP_GET && stat.live && stat.chan_ok)
					state_d = S_GET;
			end
			S_ZERO: begin
				cmd.zero_wr = 1'b1;
				k_d         = k_q + 1'b1;
				if (k_q == '1)
					state_d = S_DONE;
			end
			S_COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_d     = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				k_d         = k_q + 1'b1;
				state_d     = (k_q == '1) ? S_REMAP : S_COPY_RD;
			end
			S_REMAP: begin
				cmd.remap = 1'b1;
				state_d   = S_DONE;
			end
			S_GET: begin
				cmd.get_cap = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule

`default_nettype wire
